[sv/lifo_stack_indexed_erase_top_defines.svh]
// ----------------------------------------------------------------------------
// LIFO stack assertion macros
// Concurrent assertion wrappers for the stack design. Defining NO_ASSERTIONS
// turns every use into nothing.
// ----------------------------------------------------------------------------
`ifndef LIFO_STACK_INDEXED_ERASE_TOP_DEFINES_SVH
`define LIFO_STACK_INDEXED_ERASE_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset only.
`define LSIE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked out of reset only.
`define LSIE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LSIE_ASSERT_IMPL(lbl, ante, cons, msg)
`define LSIE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[sv/lsie_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIFO stack package
// Sizes, codes and shared types of the indexed-erase stack.
// ----------------------------------------------------------------------------
package lsie_pkg;

  localparam int DEPTH       = 16;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int OP_W        = 2;
  localparam int DIDX_W      = 4;
  localparam int COUNT_OUT_W = 5;
  localparam int STATUS_W    = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_READ  = 2'd2,
    OP_ERASE = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FETCH,
    S_RESULT
  } seq_state_t;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [DATA_W-1:0] push_value;
    logic [DIDX_W-1:0] depth_index;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0]      data_out;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic                   is_empty;
    logic [STATUS_W-1:0]    status;
  } result_t;

endpackage

[sv/lsie_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIFO stack channel interfaces
// Valid/ready channels for the operation beats and the result beats.
// ----------------------------------------------------------------------------
interface lsie_in_if;
  import lsie_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [DATA_W-1:0] push_value;
  logic [DIDX_W-1:0] depth_index;

  modport source (output valid, output opcode, output push_value, output depth_index,
                  input ready);
  modport sink   (input valid, input opcode, input push_value, input depth_index,
                  output ready);
endinterface

interface lsie_out_if;
  import lsie_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [DATA_W-1:0]      data_out;
  logic [COUNT_OUT_W-1:0] entry_count;
  logic                   is_empty;
  logic [STATUS_W-1:0]    status;

  modport source (output valid, output data_out, output entry_count, output is_empty,
                  output status, input ready);
  modport sink   (input valid, input data_out, input entry_count, input is_empty,
                  input status, output ready);
endinterface

[sv/lsie_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIFO stack entry RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lsie_ram #(
  parameter int WIDTH   = 32,
  parameter int DEPTH_P = 16
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH_P)-1:0] wr_addr,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH_P)-1:0] rd_addr,
  output logic [WIDTH-1:0]           rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH_P];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[sv/lsie_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIFO stack sequencer
// Runs one operation at a time against the entry RAM; erase closes the gap
// by moving one entry per read/write pair through the single RAM port pair.
// ----------------------------------------------------------------------------
`include "lifo_stack_indexed_erase_top_defines.svh"

module lsie_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  lsie_pkg::item_t  in_item,
  output logic             res_valid,
  input  logic             res_ready,
  output lsie_pkg::result_t res
);
  import lsie_pkg::*;

  seq_state_t        state_r, state_nxt;
  opcode_t           op_r, op_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [DIDX_W-1:0] dep_r, dep_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  status_t           status_r, status_nxt;
  logic              zero_r, zero_nxt;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [DATA_W-1:0] rd_data;

  logic              is_full;
  logic              is_zero;
  logic [ADDR_W-1:0] slot;
  logic [ADDR_W-1:0] top_addr;

  lsie_ram #(
    .WIDTH   (DATA_W),
    .DEPTH_P (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign is_zero  = (count_r == '0);
  assign top_addr = ADDR_W'(count_r - CNT_W'(1));

  // A depth at or past the count lands on the bottom entry.
  always_comb begin
    if (32'(dep_r) >= 32'(count_r)) begin
      slot = '0;
    end else begin
      slot = ADDR_W'(count_r - CNT_W'(1) - CNT_W'(dep_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    val_r    <= val_nxt;
    dep_r    <= dep_nxt;
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    zero_r   <= zero_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    val_nxt    = val_r;
    dep_nxt    = dep_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    status_nxt = status_r;
    zero_nxt   = zero_r;
    wr_en      = 1'b0;
    wr_addr    = idx_r;
    wr_data    = val_r;
    rd_en      = 1'b0;
    rd_addr    = idx_r;
    in_ready   = 1'b0;
    res_valid  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt     = opcode_t'(in_item.opcode);
          val_nxt    = in_item.push_value;
          dep_nxt    = in_item.depth_index;
          status_nxt = ST_OK;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_FETCH;
        unique case (op_r)
          OP_PUSH: begin
            if (is_full) begin
              status_nxt = ST_FULL;
            end else begin
              wr_en     = 1'b1;
              wr_addr   = ADDR_W'(count_r);
              wr_data   = val_r;
              count_nxt = count_r + CNT_W'(1);
            end
          end
          OP_POP: begin
            if (!is_zero) begin
              count_nxt = count_r - CNT_W'(1);
            end
          end
          OP_READ: begin
            idx_nxt = slot;
            if (is_zero) begin
              status_nxt = ST_EMPTY;
            end
          end
          OP_ERASE: begin
            idx_nxt = slot;
            if (is_zero) begin
              status_nxt = ST_EMPTY;
            end else begin
              state_nxt = S_SHIFT_RD;
            end
          end
          default: begin
            state_nxt = S_FETCH;
          end
        endcase
      end
      S_SHIFT_RD: begin
        // Entries above the erased slot move down one place each.
        if ((CNT_W'(idx_r) + CNT_W'(1)) < count_r) begin
          rd_en     = 1'b1;
          rd_addr   = idx_r + ADDR_W'(1);
          state_nxt = S_SHIFT_WR;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_FETCH;
        end
      end
      S_SHIFT_WR: begin
        wr_en     = 1'b1;
        wr_addr   = idx_r;
        wr_data   = rd_data;
        idx_nxt   = idx_r + ADDR_W'(1);
        state_nxt = S_SHIFT_RD;
      end
      S_FETCH: begin
        // Read returns the addressed entry; every other operation the new top.
        rd_en = 1'b1;
        if (op_r == OP_READ) begin
          rd_addr  = idx_r;
          zero_nxt = (status_r == ST_EMPTY);
        end else begin
          rd_addr  = top_addr;
          zero_nxt = is_zero;
        end
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res.data_out    = zero_r ? '0 : rd_data;
  assign res.entry_count = COUNT_OUT_W'(count_r);
  assign res.is_empty    = is_zero;
  assign res.status      = status_r;

  `LSIE_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH), "count exceeds depth")
  `LSIE_ASSERT_IMPL(a_shift_in_range, state_r == S_SHIFT_WR, (CNT_W'(idx_r) + CNT_W'(1)) < count_r, "shift past top")
  `LSIE_ASSERT_IMPL(a_full_refusal, res_valid && res.status == ST_FULL, is_full && op_r == OP_PUSH, "full status without full push")
  `LSIE_ASSERT_NEXT(a_count_hold, state_r == S_IDLE || state_r == S_RESULT, $stable(count_r), "count moved while waiting")

endmodule

[sv/lifo_stack_indexed_erase_top.sv]
`timescale 1ns / 1ps
// Push, pop and read pass through the exec, fetch and result states of the sequencer; no new
// input beat is taken until the result is handed to the output register. The result beat
// is offered from that register. Erase adds the shift states, one read and one write for each
// entry above the erased one, set by the single read and single write port of the entry RAM.
// The next beat is taken while a finished result waits in the output register.
// Reset clears the count and the output valid; entry storage is not cleared.
// ----------------------------------------------------------------------------
// LIFO stack with indexed erase, top level
// Operation sequencer plus an output register toward the result channel.
// ----------------------------------------------------------------------------
module lifo_stack_indexed_erase_top (
  input  logic       clk,
  input  logic       rst_n,
  lsie_in_if.sink    in_ch,
  lsie_out_if.source out_ch
);
  import lsie_pkg::*;

  item_t   item;
  result_t res;
  logic    res_valid;
  logic    res_ready;

  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r, out_res_nxt;

  assign item.opcode      = in_ch.opcode;
  assign item.push_value  = in_ch.push_value;
  assign item.depth_index = in_ch.depth_index;

  lsie_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_item   (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // The register takes a new result when empty or when its beat leaves now.
  assign res_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.data_out    = out_res_r.data_out;
  assign out_ch.entry_count = out_res_r.entry_count;
  assign out_ch.is_empty    = out_res_r.is_empty;
  assign out_ch.status      = out_res_r.status;

endmodule
